// ----- rtl/row_column_projection_sums_unit_macros.svh -----
// Assertion macros for the row/column projection sums unit.
// Expects clk and arst_n in the scope of each use.
`ifndef ROW_COLUMN_PROJECTION_SUMS_UNIT_MACROS_SVH
`define ROW_COLUMN_PROJECTION_SUMS_UNIT_MACROS_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define RCPS_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cond never holds.
`define RCPS_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

// ----- rtl/rcps_pkg.sv -----
// Shared types, codes and helper functions of the projection sums unit.
// No dependencies; imported by the front, back and top modules of the block.
`default_nettype none

package rcps_pkg;

	localparam int PIX_W = 16;
	localparam int IDX_W = 10;
	localparam int SUM_W = 26;
	localparam int CFG_W = 11;
	localparam int POS_W = 11;

	localparam int DEF_MAX_LINE  = 1024;
	localparam int DEF_PIXEL_BITS = 16;

	localparam int Q_DEPTH   = 4;
	localparam int OUT_DEPTH = 4;

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_READ  = 1'b1;
	localparam logic RES_ROW    = 1'b0;
	localparam logic RES_COL    = 1'b1;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

	typedef struct packed {
		logic             kind;
		logic [PIX_W-1:0] pixel;
		logic [IDX_W-1:0] column_index;
	} rcps_item_t;

	typedef struct packed {
		logic             result_kind;
		logic [IDX_W-1:0] result_index;
		logic [SUM_W-1:0] result_sum;
		logic             frame_done;
	} rcps_result_t;

	// Classified work passed from the front to the back.
	typedef struct packed {
		logic             is_read;
		logic             has_result;
		logic             first_row;
		logic             in_range;
		logic             frame_done;
		logic [IDX_W-1:0] index;
		logic [POS_W-1:0] col;
		logic [PIX_W-1:0] pix;
		logic [SUM_W-1:0] row_sum;
	} rcps_op_t;

	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
			input logic [PIX_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + (SUM_W+1)'(b);
		return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
	endfunction

	function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
			input logic [CFG_W-1:0] max_size);
		logic [CFG_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = CFG_W'(1);
		end else if (v > max_size) begin
			r = max_size;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/rcps_fifo.sv -----
// Small register FIFO used for the work queue and the result queue.
// Depends on nothing; DEPTH must be a power of two.
`default_nettype none

module rcps_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire logic [WIDTH-1:0]           push_data,
	output logic                            full,
	input  wire logic                       pop,
	output logic [WIDTH-1:0]                pop_data,
	output logic                            empty,
	output logic [$clog2(DEPTH+1)-1:0]      count
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             push_ok;
	logic             pop_ok;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign count    = count_q;
	assign pop_data = entry_q[rd_ptr_q];
	assign push_ok  = push && !full;
	assign pop_ok   = pop && !empty;

	always_ff @(posedge clk) begin
		if (push_ok) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop_ok) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			count_q <= count_q + CW'(push_ok) - CW'(pop_ok);
		end
	end

endmodule

`default_nettype wire

// ----- rtl/rcps_front.sv -----
// Front end: accepts items, tracks row/column position and the row sum.
// Depends on rcps_pkg; feeds classified work into the work queue.
`default_nettype none

module rcps_front
	import rcps_pkg::*;
#(
	parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             restart,
	input  wire logic [CFG_W-1:0] width_eff,
	input  wire logic [CFG_W-1:0] height_eff,
	input  wire rcps_item_t       item,
	input  wire logic             item_valid,
	output logic                  item_ready,
	input  wire logic             q_full,
	output logic                  q_push,
	output rcps_op_t              q_op
);

	localparam logic [PIX_W-1:0] PixMask = PIX_W'((32'd1 << PIXEL_BITS) - 32'd1);

	logic [POS_W-1:0] col_q;
	logic [POS_W-1:0] row_q;
	logic [SUM_W-1:0] acc_q;

	logic [PIX_W-1:0] pix;
	logic [SUM_W-1:0] acc_sum;
	logic [POS_W:0]   col_inc;
	logic [POS_W:0]   row_inc;
	logic             row_end;
	logic             last_row;
	logic             is_read;

	assign item_ready = !q_full;
	assign q_push     = item_valid && !q_full;
	assign is_read    = (item.kind == KIND_READ);
	assign pix        = item.pixel & PixMask;
	assign acc_sum    = sat_add(acc_q, pix);
	assign col_inc    = {1'b0, col_q} + (POS_W+1)'(1);
	assign row_inc    = {1'b0, row_q} + (POS_W+1)'(1);
	assign row_end    = (col_inc >= {1'b0, width_eff});
	assign last_row   = (row_inc >= {1'b0, height_eff});

	always_comb begin
		q_op = '0;
		q_op.is_read = is_read;
		q_op.pix     = pix;
		if (is_read) begin
			q_op.has_result = 1'b1;
			q_op.index      = item.column_index;
			q_op.col        = {1'b0, item.column_index};
			q_op.in_range   = ({1'b0, item.column_index} < width_eff);
		end else begin
			q_op.has_result = row_end;
			q_op.first_row  = (row_q == '0);
			q_op.frame_done = row_end && last_row;
			q_op.index      = row_q[IDX_W-1:0];
			q_op.col        = col_q;
			q_op.row_sum    = acc_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			acc_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
			acc_q <= '0;
		end else if (q_push && !is_read) begin
			if (row_end) begin
				col_q <= '0;
				acc_q <= '0;
				row_q <= last_row ? '0 : row_inc[POS_W-1:0];
			end else begin
				col_q <= col_inc[POS_W-1:0];
				acc_q <= acc_sum;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/rcps_back.sv -----
// Back end: column store read-modify-write and result formatting.
// Depends on rcps_pkg and rcps_fifo (result queue).
`default_nettype none

module rcps_back
	import rcps_pkg::*;
#(
	parameter int MAX_LINE = DEF_MAX_LINE
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire rcps_op_t head_op,
	input  wire logic   head_valid,
	output logic        head_pop,
	output rcps_result_t result,
	output logic        result_valid,
	input  wire logic   result_ready
);

	localparam int MemDepth = (MAX_LINE > (1 << POS_W)) ? (1 << POS_W) : MAX_LINE;
	localparam int AW       = $clog2(MemDepth);
	localparam int CW       = $clog2(OUT_DEPTH + 1);

	logic [SUM_W-1:0] store_mem [MemDepth];
	logic [SUM_W-1:0] rd_data_q;
	logic             fwd_hit_q;
	logic [SUM_W-1:0] fwd_data_q;

	rcps_op_t         op_s1;
	logic             v_s1;

	logic [AW-1:0]    head_addr;
	logic [AW-1:0]    addr_s1;
	logic [SUM_W-1:0] old_val;
	logic [SUM_W-1:0] new_val;
	logic             wr_en;
	logic [CW-1:0]    out_count;
	logic [CW:0]      in_flight;
	logic             out_push;
	logic             out_full;
	logic             out_empty;
	rcps_result_t     res_s1;
	rcps_result_t     out_data;

	assign head_addr = head_op.col[AW-1:0];
	assign addr_s1   = op_s1.col[AW-1:0];

	// Reserve result queue space for everything already in flight.
	assign in_flight = {1'b0, out_count} + (CW+1)'(v_s1);
	assign head_pop  = head_valid && (in_flight < (CW+1)'(OUT_DEPTH));

	assign old_val = fwd_hit_q ? fwd_data_q : rd_data_q;
	assign new_val = op_s1.first_row ? SUM_W'(op_s1.pix) : sat_add(old_val, op_s1.pix);
	assign wr_en   = v_s1 && !op_s1.is_read;

	always_ff @(posedge clk) begin
		rd_data_q <= store_mem[head_addr];
		if (wr_en) begin
			store_mem[addr_s1] <= new_val;
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= new_val;
		if (head_pop) begin
			op_s1 <= head_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			fwd_hit_q <= 1'b0;
		end else begin
			v_s1      <= head_pop;
			fwd_hit_q <= wr_en && (addr_s1 == head_addr);
		end
	end

	always_comb begin
		res_s1 = '0;
		res_s1.result_index = op_s1.index;
		if (op_s1.is_read) begin
			res_s1.result_kind = RES_COL;
			res_s1.result_sum  = op_s1.in_range ? old_val : '0;
		end else begin
			res_s1.result_kind = RES_ROW;
			res_s1.result_sum  = op_s1.row_sum;
			res_s1.frame_done  = op_s1.frame_done;
		end
	end

	assign out_push = v_s1 && op_s1.has_result;

	rcps_fifo #(
		.WIDTH($bits(rcps_result_t)),
		.DEPTH(OUT_DEPTH)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (out_push),
		.push_data (res_s1),
		.full      (out_full),
		.pop       (result_ready),
		.pop_data  (out_data),
		.empty     (out_empty),
		.count     (out_count)
	);

	// The reservation above keeps pushes off a full queue.
	assign result       = out_data;
	assign result_valid = !out_empty && !(out_full && 1'b0);

endmodule

`default_nettype wire

// ----- rtl/row_column_projection_sums_unit.sv -----
// Row/column projection sums: one item per cycle sustained, input and output,
// while result_ready holds. Path to result valid: work queue, column store read
// stage (registered store read), result queue. Reset: clears positions, row sum
// and both queues; width/height to 1024. The column store is not cleared; the user
// must not read an entry before a pixel writes it; the block does not enforce this.
`default_nettype none

`include "row_column_projection_sums_unit_macros.svh"

module row_column_projection_sums_unit
	import rcps_pkg::*;
#(
	parameter int MAX_LINE   = DEF_MAX_LINE,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// Input items
	input  wire rcps_item_t   item,
	input  wire logic         item_valid,
	output logic              item_ready,
	// Result items
	output rcps_result_t      result,
	output logic              result_valid,
	input  wire logic         result_ready,
	// Configuration port
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	// Largest usable region size: bounded by the line store and the register width.
	localparam int MaxSizeI = (MAX_LINE > ((1 << CFG_W) - 1)) ? ((1 << CFG_W) - 1) : MAX_LINE;
	localparam logic [CFG_W-1:0] MaxSize = CFG_W'(MaxSizeI);

	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic [CFG_W-1:0] width_eff;
	logic [CFG_W-1:0] height_eff;
	logic [CFG_W-1:0] height_m1;
	logic             cfg_wr;
	logic             reg_sel;

	logic             q_push;
	logic             q_full;
	logic             q_empty;
	logic             q_pop;
	rcps_op_t         q_in_op;
	rcps_op_t         q_head_op;

	logic             col_res_valid;
	logic             col_beyond;

	// ------------------------------------------------------------------
	// Configuration registers; word aligned, low address bits ignored.
	// ------------------------------------------------------------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_RESET;
			height_q <= CFG_RESET;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_WIDTH: begin
					width_q <= pwdata[CFG_W-1:0];
				end
				REG_HEIGHT: begin
					height_q <= pwdata[CFG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_WIDTH:  prdata = {{(32-CFG_W){1'b0}}, width_q};
			REG_HEIGHT: prdata = {{(32-CFG_W){1'b0}}, height_q};
			default:    prdata = '0;
		endcase
	end

	// Zero acts as one; anything above the line store acts as its size.
	assign width_eff  = clamp_size(width_q, MaxSize);
	assign height_eff = clamp_size(height_q, MaxSize);
	assign height_m1  = height_eff - CFG_W'(1);

	// ------------------------------------------------------------------
	// Front: classify each transfer, advance position, build the row sum.
	// A register write restarts the frame.
	// ------------------------------------------------------------------
	rcps_front #(
		.PIXEL_BITS(PIXEL_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (cfg_wr),
		.width_eff  (width_eff),
		.height_eff (height_eff),
		.item       (item),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_op       (q_in_op)
	);

	// Work queue: decouple the front from stalls on the result side.
	rcps_fifo #(
		.WIDTH($bits(rcps_op_t)),
		.DEPTH(Q_DEPTH)
	) u_work_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in_op),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_head_op),
		.empty     (q_empty),
		.count     ()
	);

	// ------------------------------------------------------------------
	// Back: column store read-modify-write with forwarding, result queue.
	// ------------------------------------------------------------------
	rcps_back #(
		.MAX_LINE(MAX_LINE)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_op      (q_head_op),
		.head_valid   (!q_empty),
		.head_pop     (q_pop),
		.result       (result),
		.result_valid (result_valid),
		.result_ready (result_ready)
	);

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	assign col_res_valid = result_valid && (result.result_kind == RES_COL);
	assign col_beyond    = ({1'b0, result.result_index} >= width_eff);

	`RCPS_ASSERT_NEVER(a_col_no_frame_done, col_res_valid && result.frame_done, "frame_done set on a column result")

	`RCPS_ASSERT_IMPLIES(a_col_beyond_zero, col_res_valid && col_beyond, result.result_sum == '0, "column beyond width returned nonzero sum")

	`RCPS_ASSERT_IMPLIES(a_frame_done_last_row, result_valid && result.frame_done, result.result_index == height_m1[IDX_W-1:0], "frame_done on a row other than the last")

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench of row_column_projection_sums_unit: a directed stimulus table,
// then random configuration phases, checked against typed sums or the in-bench predictor.
// Depends on rcps_pkg and the row_column_projection_sums_unit RTL only.

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rcps_pkg::*;

	localparam int PERIOD        = 20;
	localparam int RESET_CYCLES  = 10;
	localparam int LINE_MAX      = 1024;
	// Leave margin for pixels still in flight that owe no result.
	localparam int SETTLE_CYCLES = 8;
	localparam int ITEM_TARGET   = 1350;
	localparam int HOLD_CYCLES   = 300;
	// Longest honest gap without a transfer is the receiver hold plus a sender gap;
	// allow more than ten times that.
	localparam int HANG_LIMIT    = 4000;
	localparam int PRINT_LIMIT   = 50;
	localparam logic [SUM_W-1:0] SUM_CEIL = '1;

	typedef enum logic {STEP_ITEM, STEP_WRITE} step_t;

	// One row of the directed table: either a register write or an item, with the
	// expected result typed in where it is obvious.
	typedef struct packed {
		step_t            what;
		logic             reg_sel;
		logic [CFG_W-1:0] value;
		rcps_item_t       payload;
		logic             typed;
		rcps_result_t     want;
	} plan_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	rcps_item_t        item;
	logic              item_valid;
	logic              item_ready;
	rcps_result_t      result;
	logic              result_valid;
	logic              result_ready;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [2:0]        paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	// Projection predictor state: column store, running row sum, raster position,
	// and its own copy of the two size registers.
	logic [SUM_W-1:0]  col_sums [LINE_MAX];
	bit                col_written [LINE_MAX];
	logic [SUM_W-1:0]  row_sum_acc;
	int unsigned       col_at;
	int unsigned       row_at;
	logic [CFG_W-1:0]  width_reg;
	logic [CFG_W-1:0]  height_reg;

	// Sums predicted but not yet seen on the result channel, oldest first.
	rcps_result_t      sums_due [$];

	int                error_count = 0;
	int                send_idle_pct = 0;
	int                recv_idle_pct = 0;
	bit                hold_req = 1'b0;
	int                stall_cycles = 0;

	row_column_projection_sums_unit i_dut (
		.clk,
		.arst_n,
		.item,
		.item_valid,
		.item_ready,
		.result,
		.result_valid,
		.result_ready,
		.psel,
		.penable,
		.pwrite,
		.paddr,
		.pwdata,
		.prdata,
		.pready
	);

	always #(PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Size register as the block uses it: zero means one, anything above the
	// line store means the full line.
	function automatic int unsigned effective_size(input logic [CFG_W-1:0] v);
		if (v == '0) return 1;
		if (v > LINE_MAX) return LINE_MAX;
		return v;
	endfunction

	function automatic logic [SUM_W-1:0] add_sat(input logic [SUM_W-1:0] a,
			input logic [PIX_W-1:0] b);
		logic [SUM_W:0] total;
		total = {1'b0, a} + {{(SUM_W + 1 - PIX_W){1'b0}}, b};
		return (total > SUM_CEIL) ? SUM_CEIL : total[SUM_W-1:0];
	endfunction

	// Advance the predictor by one accepted item; return 1 when it owes a result.
	function automatic bit project_item(input rcps_item_t it, output rcps_result_t r);
		int unsigned w;
		int unsigned h;
		w = effective_size(width_reg);
		h = effective_size(height_reg);
		r = '0;
		if (it.kind == KIND_READ) begin
			r.result_kind  = RES_COL;
			r.result_index = it.column_index;
			r.result_sum   = (it.column_index < w) ? col_sums[it.column_index] : '0;
			r.frame_done   = 1'b0;
			return 1'b1;
		end
		// First row of a frame overwrites the column, later rows accumulate.
		if (row_at == 0) begin
			col_sums[col_at] = {{(SUM_W - PIX_W){1'b0}}, it.pixel};
		end else begin
			col_sums[col_at] = add_sat(col_sums[col_at], it.pixel);
		end
		col_written[col_at] = 1'b1;
		row_sum_acc = add_sat(row_sum_acc, it.pixel);
		if (col_at + 1 < w) begin
			col_at++;
			return 1'b0;
		end
		r.result_kind  = RES_ROW;
		r.result_index = row_at[IDX_W-1:0];
		r.result_sum   = row_sum_acc;
		r.frame_done   = (row_at + 1 >= h);
		row_at      = r.frame_done ? 0 : row_at + 1;
		col_at      = 0;
		row_sum_acc = '0;
		return 1'b1;
	endfunction

	// Any register write restarts the frame; the column store keeps its contents.
	function automatic void note_write(input logic sel, input logic [CFG_W-1:0] v);
		if (sel == REG_WIDTH) begin
			width_reg = v;
		end else begin
			height_reg = v;
		end
		col_at      = 0;
		row_at      = 0;
		row_sum_acc = '0;
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic note_error(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (error_count < PRINT_LIMIT) begin
			$display("ERROR %s: got %0h, want %0h (t=%0t)", what, got, want, $time);
		end
		error_count++;
	endtask

	// Compare one result transfer against the oldest sum due, field by field.
	task automatic check_result(input rcps_result_t got);
		rcps_result_t want;
		if (sums_due.size() == 0) begin
			note_error("result with no sum due", got, '0);
		end else begin
			want = sums_due.pop_front();
			if (got.result_kind !== want.result_kind)
				note_error("result_kind", got.result_kind, want.result_kind);
			if (got.result_index !== want.result_index)
				note_error("result_index", got.result_index, want.result_index);
			if (got.result_sum !== want.result_sum)
				note_error("result_sum", got.result_sum, want.result_sum);
			if (got.frame_done !== want.frame_done)
				note_error("frame_done", got.frame_done, want.frame_done);
		end
	endtask

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// Offer one item and hold it until the transfer; predict at the transfer edge.
	// Call at a rising edge; valid is left high so back-to-back items need no gap.
	task automatic send_item(input rcps_item_t it, input logic typed,
			input rcps_result_t want);
		rcps_result_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		if (project_item(it, r)) sums_due.push_back(typed ? want : r);
	endtask

	// Drain the block, then do one APB write (setup cycle, then access cycle).
	task automatic write_register(input logic sel, input logic [CFG_W-1:0] v);
		item_valid <= 1'b0;
		while (sums_due.size() != 0) @(posedge clk);
		// Pixels that end no row leave no trace in sums_due; let them retire too.
		repeat (SETTLE_CYCLES) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		note_write(sel, v);
	endtask

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic plan_row_t pixel_row(input logic [PIX_W-1:0] p);
		plan_row_t r;
		r = '0;
		r.what          = STEP_ITEM;
		r.payload.kind  = KIND_PIXEL;
		r.payload.pixel = p;
		return r;
	endfunction

	function automatic plan_row_t read_row(input logic [IDX_W-1:0] c);
		plan_row_t r;
		r = '0;
		r.what                 = STEP_ITEM;
		r.payload.kind         = KIND_READ;
		r.payload.column_index = c;
		return r;
	endfunction

	function automatic plan_row_t write_row(input logic sel, input logic [CFG_W-1:0] v);
		plan_row_t r;
		r = '0;
		r.what    = STEP_WRITE;
		r.reg_sel = sel;
		r.value   = v;
		return r;
	endfunction

	function automatic plan_row_t expecting(input plan_row_t r, input logic k,
			input logic [IDX_W-1:0] idx, input logic [SUM_W-1:0] s, input logic fd);
		plan_row_t o;
		o = r;
		o.typed             = 1'b1;
		o.want.result_kind  = k;
		o.want.result_index = idx;
		o.want.result_sum   = s;
		o.want.frame_done   = fd;
		return o;
	endfunction

	// Random item with random content in every field; reads never touch a column
	// inside the width that no pixel has written since reset.
	function automatic rcps_item_t random_item(input int read_pct);
		rcps_item_t  it;
		int unsigned w;
		int unsigned c;
		w = effective_size(width_reg);
		it.kind         = KIND_PIXEL;
		it.pixel        = PIX_W'($urandom);
		it.column_index = IDX_W'($urandom);
		case ($urandom_range(7))
			0: it.pixel = '1;
			1: it.pixel = '0;
			default: ;
		endcase
		if ($urandom_range(99) < read_pct) begin
			it.kind = KIND_READ;
			case ($urandom_range(2))
				0: c = $urandom_range(w - 1, 0);
				1: c = (w < LINE_MAX) ? $urandom_range(LINE_MAX - 1, w)
					: $urandom_range(LINE_MAX - 1, 0);
				default: c = $urandom_range(LINE_MAX - 1, 0);
			endcase
			if (c < w && !col_written[c]) begin
				if (w < LINE_MAX) begin
					c = $urandom_range(LINE_MAX - 1, w);
				end else begin
					it.kind = KIND_PIXEL;
				end
			end
			it.column_index = IDX_W'(c);
		end
		return it;
	endfunction

	// ------------------------------------------------------------------
	// Result side: random back-pressure plus one long hold on request
	// ------------------------------------------------------------------

	initial begin
		int hold_left;
		hold_left = 0;
		result_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_valid && result_ready) check_result(result);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: count cycles without any transfer
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		while (stall_cycles < HANG_LIMIT) @(posedge clk);
		$display("row_column_projection_sums_unit verification failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin
		plan_row_t    plan [$];
		rcps_item_t   it;
		rcps_result_t none;
		int           issued;
		bit           big_done;
		int           n;
		int           mode;
		bit           squeeze_done;
		logic [CFG_W-1:0] w_val;
		logic [CFG_W-1:0] h_val;

		none         = '0;
		issued       = 0;
		big_done     = 1'b0;
		squeeze_done = 1'b0;

		// Hold every input at a known value from time zero.
		arst_n     <= 1'b0;
		item       <= '0;
		item_valid <= 1'b0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= '0;

		width_reg   = CFG_RESET;
		height_reg  = CFG_RESET;
		row_sum_acc = '0;
		col_at      = 0;
		row_at      = 0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table. Starts from the reset sizes (1024 by 1024).
		plan.push_back(pixel_row(16'hFFFF));
		plan.push_back(expecting(read_row(10'd0), RES_COL, 10'd0, 26'd65535, 1'b0));
		// Width zero acts as one pixel per row.
		plan.push_back(write_row(REG_WIDTH, 11'd0));
		plan.push_back(write_row(REG_HEIGHT, 11'd2));
		plan.push_back(expecting(pixel_row(16'hFFFF), RES_ROW, 10'd0, 26'd65535, 1'b0));
		plan.push_back(expecting(pixel_row(16'h0000), RES_ROW, 10'd1, 26'd0, 1'b1));
		plan.push_back(expecting(read_row(10'd0), RES_COL, 10'd0, 26'd65535, 1'b0));
		// Reads beyond the width return zero.
		plan.push_back(expecting(read_row(10'd1023), RES_COL, 10'd1023, 26'd0, 1'b0));
		plan.push_back(expecting(read_row(10'd1), RES_COL, 10'd1, 26'd0, 1'b0));
		// Height zero acts as a one-row frame.
		plan.push_back(write_row(REG_WIDTH, 11'd3));
		plan.push_back(write_row(REG_HEIGHT, 11'd0));
		plan.push_back(pixel_row(16'd1));
		plan.push_back(pixel_row(16'd2));
		plan.push_back(expecting(pixel_row(16'd3), RES_ROW, 10'd0, 26'd6, 1'b1));
		plan.push_back(expecting(read_row(10'd2), RES_COL, 10'd2, 26'd3, 1'b0));
		plan.push_back(expecting(read_row(10'd3), RES_COL, 10'd3, 26'd0, 1'b0));
		plan.push_back(write_row(REG_WIDTH, 11'd2));
		plan.push_back(write_row(REG_HEIGHT, 11'd3));
		plan.push_back(pixel_row(16'h8000));
		plan.push_back(expecting(pixel_row(16'h7FFF), RES_ROW, 10'd0, 26'd65535, 1'b0));
		plan.push_back(pixel_row(16'h5555));
		plan.push_back(expecting(pixel_row(16'hAAAA), RES_ROW, 10'd1, 26'd65535, 1'b0));
		plan.push_back(pixel_row(16'h0000));
		plan.push_back(expecting(pixel_row(16'h0000), RES_ROW, 10'd2, 26'd0, 1'b1));
		plan.push_back(read_row(10'd0));
		plan.push_back(read_row(10'd1));
		// Size writes restart the frame but keep the column store.
		plan.push_back(write_row(REG_WIDTH, 11'd1024));
		plan.push_back(write_row(REG_HEIGHT, 11'd2047));
		plan.push_back(read_row(10'd0));

		foreach (plan[i]) begin
			if (plan[i].what == STEP_WRITE) begin
				write_register(plan[i].reg_sel, plan[i].value);
			end else begin
				send_item(plan[i].payload, plan[i].typed, plan[i].want);
			end
		end

		// Random phases: new sizes, then a burst of items with random content.
		while (issued < ITEM_TARGET) begin
			// Idle pattern: sender light / receiver heavy, then swapped, then none.
			// The full-size phase alone is most of the items, so it opens the last mode.
			mode = (issued < ITEM_TARGET / 9) ? 0 : (issued < 2 * ITEM_TARGET / 9) ? 1 : 2;
			send_idle_pct = (mode == 0) ? 24 : (mode == 1) ? 57 : 0;
			recv_idle_pct = (mode == 0) ? 57 : (mode == 1) ? 24 : 0;

			if (mode == 2 && !big_done) begin
				big_done = 1'b1;
				// One full-size phase: either one clamped-wide row or a clamped-tall frame and more rows.
				if ($urandom_range(1) == 1) begin
					write_register(REG_WIDTH, 11'd2047);
					write_register(REG_HEIGHT, 11'd0);
					for (int k = 0; k < LINE_MAX; k++) begin
						it = '0;
						it.kind  = KIND_PIXEL;
						it.pixel = PIX_W'($urandom_range(65535, 32768));
						send_item(it, 1'b0, none);
					end
					it = '0;
					it.kind = KIND_READ;
					it.column_index = 10'd1023;
					send_item(it, 1'b0, none);
					it.column_index = IDX_W'($urandom_range(LINE_MAX - 1, 0));
					send_item(it, 1'b0, none);
					issued += LINE_MAX + 2;
				end else begin
					write_register(REG_WIDTH, 11'd0);
					write_register(REG_HEIGHT, 11'd2047);
					for (int k = 0; k < LINE_MAX + 16; k++) begin
						it = '0;
						if (k % 128 == 127) begin
							it.kind = KIND_READ;
						end else begin
							it.kind  = KIND_PIXEL;
							it.pixel = PIX_W'($urandom_range(65535, 32768));
						end
						send_item(it, 1'b0, none);
					end
					issued += LINE_MAX + 16;
				end
			end else begin
				// Mostly small regions so that rows and frames end often.
				case ($urandom_range(9))
					0: w_val = 11'd0;
					1: w_val = 11'd1;
					2, 3: w_val = CFG_W'($urandom_range(40, 9));
					default: w_val = CFG_W'($urandom_range(8, 2));
				endcase
				h_val = ($urandom_range(15) == 0) ? 11'd2047 : CFG_W'($urandom_range(6, 0));
				// Write both in random order, or only one of them now and then.
				case ($urandom_range(9))
					0: write_register(REG_WIDTH, w_val);
					1: write_register(REG_HEIGHT, h_val);
					2, 3, 4: begin
						write_register(REG_HEIGHT, h_val);
						write_register(REG_WIDTH, w_val);
					end
					default: begin
						write_register(REG_WIDTH, w_val);
						write_register(REG_HEIGHT, h_val);
					end
				endcase
				n = $urandom_range(80, 20);
				// Once, stall the result side for a long stretch while items keep
				// coming, so the block fills and drops item_ready.
				if (mode == 1 && !squeeze_done) begin
					squeeze_done = 1'b1;
					hold_req     = 1'b1;
					n            = 80;
				end
				for (int k = 0; k < n; k++) begin
					send_item(random_item(25), 1'b0, none);
				end
				issued += n;
			end
		end

		// Drop valid, let every due sum arrive, then watch for strays.
		item_valid <= 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		while (sums_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (error_count == 0) begin
			$display("row_column_projection_sums_unit verification clean");
		end else begin
			$display("row_column_projection_sums_unit verification failed");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/rcps_pkg.sv
rtl/rcps_fifo.sv
rtl/rcps_front.sv
rtl/rcps_back.sv
rtl/row_column_projection_sums_unit.sv
tb/sv/tb.sv
